// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file cstc_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/cstc_pkg.sv =====
// ----------------------------------------------------------------------------
// cstc_pkg
// Shared widths, status codes and control types of the Collatz step counter.
// ----------------------------------------------------------------------------
package cstc_pkg;

	localparam int VALUE_WIDTH = 128;
	localparam int HALF_WIDTH  = 64;
	localparam int CTZ_W       = $clog2(VALUE_WIDTH);
	localparam int FUSE_W      = 63;
	localparam int STEP_W      = FUSE_W + 1;
	localparam int STATUS_W    = 2;

	localparam logic [FUSE_W-1:0] FUSE_RESET = FUSE_W'(100000000);

	localparam logic [STATUS_W-1:0] STATUS_ONE      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_LIMIT    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_ZERO     = 2'd3;

	typedef logic [VALUE_WIDTH-1:0] value_t;
	typedef logic [CTZ_W-1:0]       zcount_t;

	// operation of the shared datapath for one cycle
	typedef enum logic [2:0] {
		OP_HOLD,
		OP_LOAD,
		OP_TRIPLE,
		OP_ZCOUNT,
		OP_SHIFT
	} op_t;

	// value condition flags back to the sequencer
	typedef struct packed {
		logic is_zero;
		logic is_one;
		logic is_odd;
		logic ovf;
	} flags_t;

endpackage

// ===== rtl/core/collatz_accelerated_step_counter_core.sv =====
// ----------------------------------------------------------------------------
// collatz_accelerated_step_counter_core
// Accelerated Collatz total stopping time of a 128-bit start value.
//
// Channel   Dir  Handshake            Word
// in        in   in_valid/in_ready    n_low, n_high (start value halves)
// out       out  out_valid/out_ready  status, steps
// cfg       in   cfg_we (no wait)     cfg_wdata -> step fuse
//
// A run to one is a load, then the even and odd passes: zero count and shift
// for an even pass, odd test, 3n+1, zero count and shift for an odd one, then
// a closing test and the FINISH state. A fuse or overflow stop skips the
// closing test; an overflow pass ends at its 3n+1 step.
// The next word is accepted while a result waits; a new result holds in FINISH
// until the output slot frees, which adds the receiver's stall to the run.
// Reset idles the sequencer, clears output valid and loads the fuse with 1e8.
// ----------------------------------------------------------------------------
module collatz_accelerated_step_counter_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [cstc_pkg::HALF_WIDTH-1:0]   n_low,
	input  logic [cstc_pkg::HALF_WIDTH-1:0]   n_high,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [cstc_pkg::STATUS_W-1:0]     status,
	output logic [cstc_pkg::FUSE_W-1:0]       steps,
	input  logic                              cfg_we,
	input  logic [cstc_pkg::FUSE_W-1:0]       cfg_wdata
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXAMINE,
		ST_TRIPLE,
		ST_SHIFT,
		ST_FINISH
	} state_t;

	localparam int START_W = 2 * cstc_pkg::HALF_WIDTH;

	state_t                          state_q;
	logic [cstc_pkg::FUSE_W-1:0]     fuse_q;
	logic [cstc_pkg::STEP_W-1:0]     count_q;
	logic [cstc_pkg::STEP_W-1:0]     count_next;
	logic                            plus1_q;
	logic [cstc_pkg::STATUS_W-1:0]   result_q;
	logic                            out_valid_q;
	logic [cstc_pkg::STATUS_W-1:0]   status_q;
	logic [cstc_pkg::FUSE_W-1:0]     steps_q;
	logic [START_W-1:0]              start_word;
	logic                            over_fuse;
	logic                            out_free;

	cstc_pkg::op_t     op;
	cstc_pkg::flags_t  flags;
	cstc_pkg::zcount_t zcount;

	// bits at or above the value width are dropped
	assign start_word = {n_high, n_low};

	cstc_datapath u_datapath (
		.clk        (clk),
		.op         (op),
		.load_value (start_word[cstc_pkg::VALUE_WIDTH-1:0]),
		.flags      (flags),
		.zcount     (zcount)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign steps     = steps_q;
	assign out_free  = !out_valid_q || out_ready;

	// a pass adds its stripped zeros plus one for a 3n+1 step
	assign count_next = count_q + cstc_pkg::STEP_W'(zcount) + cstc_pkg::STEP_W'(plus1_q);
	assign over_fuse  = count_next > {1'b0, fuse_q};

	// drive the shared datapath from the sequencer state
	always_comb begin
		op = cstc_pkg::OP_HOLD;
		case (state_q)
			ST_IDLE:    if (in_valid) op = cstc_pkg::OP_LOAD;
			ST_EXAMINE: op = cstc_pkg::OP_ZCOUNT;
			ST_TRIPLE:  if (!flags.ovf) op = cstc_pkg::OP_TRIPLE;
			ST_SHIFT:   op = cstc_pkg::OP_SHIFT;
			default:    op = cstc_pkg::OP_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fuse_q      <= cstc_pkg::FUSE_RESET;
			count_q     <= '0;
			plus1_q     <= 1'b0;
			result_q    <= cstc_pkg::STATUS_ONE;
			out_valid_q <= 1'b0;
			status_q    <= cstc_pkg::STATUS_ONE;
			steps_q     <= '0;
		end else begin
			if (cfg_we) begin
				fuse_q <= cfg_wdata;
			end
			// drop the result once taken; in FINISH the slot is refilled below
			if (out_valid_q && out_ready && (state_q != ST_FINISH)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						count_q <= '0;
						plus1_q <= 1'b0;
						state_q <= ST_EXAMINE;
					end
				end
				ST_EXAMINE: begin
					// zero can only show on the first look, the run never makes it
					if (flags.is_zero) begin
						result_q <= cstc_pkg::STATUS_ZERO;
						state_q  <= ST_FINISH;
					end else if (flags.is_one) begin
						result_q <= cstc_pkg::STATUS_ONE;
						state_q  <= ST_FINISH;
					end else if (flags.is_odd) begin
						state_q <= ST_TRIPLE;
					end else begin
						state_q <= ST_SHIFT;
					end
				end
				ST_TRIPLE: begin
					// overflow keeps the count from before this step
					if (flags.ovf) begin
						result_q <= cstc_pkg::STATUS_OVERFLOW;
						state_q  <= ST_FINISH;
					end else begin
						plus1_q <= 1'b1;
						state_q <= ST_EXAMINE;
					end
				end
				ST_SHIFT: begin
					// fuse is checked after every whole pass, before the value test
					count_q <= count_next;
					plus1_q <= 1'b0;
					if (over_fuse) begin
						result_q <= cstc_pkg::STATUS_LIMIT;
						state_q  <= ST_FINISH;
					end else begin
						state_q <= ST_EXAMINE;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						status_q    <= result_q;
						// saturate a count past the port width
						steps_q     <= count_q[cstc_pkg::STEP_W-1] ? '1
						               : count_q[cstc_pkg::FUSE_W-1:0];
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/core/cstc_ctz.sv =====
// ----------------------------------------------------------------------------
// cstc_ctz
// Trailing zero count of the working value: isolate the lowest set bit, encode.
// ----------------------------------------------------------------------------
module cstc_ctz (
	input  cstc_pkg::value_t  value,
	output cstc_pkg::zcount_t zcount
);

	cstc_pkg::value_t lowest;

	assign lowest = value & (~value + cstc_pkg::value_t'(1));

	always_comb begin
		zcount = '0;
		for (int i = 0; i < cstc_pkg::VALUE_WIDTH; i++) begin
			zcount = zcount | (cstc_pkg::CTZ_W'(i) & {cstc_pkg::CTZ_W{lowest[i]}});
		end
	end

endmodule

// ===== rtl/core/cstc_datapath.sv =====
// ----------------------------------------------------------------------------
// cstc_datapath
// Working value register with the shared 3n+1 adder, zero counter and shifter.
// ----------------------------------------------------------------------------
module cstc_datapath (
	input  logic              clk,
	input  cstc_pkg::op_t     op,
	input  cstc_pkg::value_t  load_value,
	output cstc_pkg::flags_t  flags,
	output cstc_pkg::zcount_t zcount
);

	localparam int SUM_W = cstc_pkg::VALUE_WIDTH + 2;

	cstc_pkg::value_t  n_q;
	cstc_pkg::zcount_t z_q;
	cstc_pkg::zcount_t z_next;
	logic [SUM_W-1:0]  triple_sum;

	cstc_ctz u_ctz (
		.value  (n_q),
		.zcount (z_next)
	);

	// 3n+1 = n + 2n + 1, two guard bits catch the carry out of the value width
	assign triple_sum = {2'b00, n_q} + {1'b0, n_q, 1'b0} + SUM_W'(1);

	assign flags.is_zero = (n_q == '0);
	assign flags.is_one  = (n_q == cstc_pkg::value_t'(1));
	assign flags.is_odd  = n_q[0];
	assign flags.ovf     = |triple_sum[SUM_W-1:cstc_pkg::VALUE_WIDTH];
	assign zcount        = z_q;

	always_ff @(posedge clk) begin
		case (op)
			cstc_pkg::OP_LOAD:   n_q <= load_value;
			cstc_pkg::OP_TRIPLE: n_q <= triple_sum[cstc_pkg::VALUE_WIDTH-1:0];
			cstc_pkg::OP_ZCOUNT: z_q <= z_next;
			cstc_pkg::OP_SHIFT:  n_q <= n_q >> z_q;
			default: begin
			end
		endcase
	end

endmodule

// ===== rtl/core/cstc_checker.sv =====
// ----------------------------------------------------------------------------
// cstc_checker
// Port-level checks of the Collatz step counter, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cstc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic [cstc_pkg::HALF_WIDTH-1:0] n_low,
	input logic [cstc_pkg::HALF_WIDTH-1:0] n_high,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [cstc_pkg::STATUS_W-1:0]   status,
	input logic [cstc_pkg::FUSE_W-1:0]     steps
);

	logic [2*cstc_pkg::HALF_WIDTH-1:0]                 in_word;
	logic [cstc_pkg::STATUS_W+cstc_pkg::FUSE_W-1:0]    out_word;

	assign in_word  = {n_high, n_low};
	assign out_word = {status, steps};

	// a taken word keeps the block busy for at least the next cycle
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

	// a waiting input word holds
	`ASSERT_NEXT(a_in_hold, clk, arst_n, in_valid && !in_ready, in_valid && $stable(in_word))

	// a zero start value reports no steps
	`ASSERT_SAME(a_zero_steps, clk, arst_n, out_valid && status == cstc_pkg::STATUS_ZERO, steps == '0)

	// a stalled result holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_word))

endmodule

bind collatz_accelerated_step_counter_core cstc_checker u_cstc_checker (.*);

// ===== tb/collatz_accelerated_step_counter_core_tb.sv =====
// ----------------------------------------------------------------------------
// collatz_accelerated_step_counter_core_tb
// Self-checking bench for the accelerated Collatz step counter core.
//
// Start values go in as words on the input channel. A scoreboard class runs
// its own 128-bit iteration on every accepted word and holds the expected
// status and step count in order. Each result word is checked field by field
// against the oldest expectation. The fuse register is rewritten between
// phases, only after all results are back: zero, the full 63-bit range, the
// reset value, a few exact limits and random small limits. The sender and the
// receiver both idle at random. One long receiver hold-off backs the core up
// while the sender keeps offering words.
// ----------------------------------------------------------------------------
module collatz_accelerated_step_counter_core_tb;

	localparam int VALUE_WIDTH = cstc_pkg::VALUE_WIDTH;
	localparam int HALF_WIDTH  = cstc_pkg::HALF_WIDTH;
	localparam int FUSE_W      = cstc_pkg::FUSE_W;
	localparam int STATUS_W    = cstc_pkg::STATUS_W;

	localparam int unsigned HOLD_OFF_CYCLES = 400;
	localparam int unsigned SETTLE_CYCLES   = 20;

	typedef cstc_pkg::value_t value_t;

	// one expected result word
	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [FUSE_W-1:0]   steps;
	} outcome_t;

	// ------------------------------------------------------------------------
	// Scoreboard: own copy of the fuse, own iteration, FIFO of expectations.
	// ------------------------------------------------------------------------
	class stopping_time_scoreboard;
		logic [FUSE_W-1:0] fuse;
		outcome_t          awaited_outcomes[$];
		int unsigned       mismatches;
		int unsigned       results_seen;

		function new();
			fuse         = cstc_pkg::FUSE_RESET;
			mismatches   = 0;
			results_seen = 0;
		endfunction

		function void set_fuse(logic [FUSE_W-1:0] value);
			fuse = value;
		endfunction

		function int unsigned pending();
			return awaited_outcomes.size();
		endfunction

		// v is never zero here
		function int unsigned trailing_zeros(value_t v);
			int unsigned c;
			c = 0;
			while (!v[c])
				c++;
			return c;
		endfunction

		function outcome_t stopping_time(value_t start);
			value_t                 v;
			logic [VALUE_WIDTH+1:0] tripled;
			logic [63:0]            count;
			int unsigned            z;
			outcome_t               r;
			v        = start;
			count    = '0;
			r.status = cstc_pkg::STATUS_ONE;
			if (v == '0) begin
				r.status = cstc_pkg::STATUS_ZERO;
			end else begin
				while (v != value_t'(1)) begin
					if (!v[0]) begin
						// even: strip all trailing zeros in one pass
						z = trailing_zeros(v);
						v = v >> z;
						count += 64'(z);
					end else begin
						// odd: 3n+1 must fit in the value width, else stop
						tripled = (VALUE_WIDTH+2)'(v) * 3 + 1;
						if (tripled[VALUE_WIDTH+1:VALUE_WIDTH] != 2'b00) begin
							r.status = cstc_pkg::STATUS_OVERFLOW;
							break;
						end
						z = trailing_zeros(tripled[VALUE_WIDTH-1:0]);
						v = tripled[VALUE_WIDTH-1:0] >> z;
						count += 64'(z) + 64'd1;
					end
					// fuse is checked only after a whole pass
					if (count > {1'b0, fuse}) begin
						r.status = cstc_pkg::STATUS_LIMIT;
						break;
					end
				end
			end
			// saturate a count that does not fit the result field
			r.steps = (count > {1'b0, {FUSE_W{1'b1}}}) ? {FUSE_W{1'b1}} : count[FUSE_W-1:0];
			return r;
		endfunction

		function void note_start(logic [HALF_WIDTH-1:0] lo, logic [HALF_WIDTH-1:0] hi);
			awaited_outcomes.push_back(stopping_time({hi, lo}));
		endfunction

		function void check_outcome(logic [STATUS_W-1:0] status, logic [FUSE_W-1:0] steps);
			outcome_t want;
			results_seen++;
			if (awaited_outcomes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d with nothing expected: status %0d steps %0d",
						results_seen, status, steps);
				return;
			end
			want = awaited_outcomes.pop_front();
			if (want.status !== status || want.steps !== steps) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result %0d: status exp %0d got %0d, steps exp %0d got %0d",
						results_seen, want.status, status, want.steps, steps);
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset and block inputs, all known from time zero.
	// ------------------------------------------------------------------------
	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic [HALF_WIDTH-1:0] n_low     = '0;
	logic [HALF_WIDTH-1:0] n_high    = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [STATUS_W-1:0]   status;
	logic [FUSE_W-1:0]     steps;
	logic                  cfg_we    = 1'b0;
	logic [FUSE_W-1:0]     cfg_wdata = '0;

	// steady: no idling on either side; hold_off_req: ask receiver for a long stall
	bit steady       = 1'b0;
	bit hold_off_req = 1'b0;

	stopping_time_scoreboard sb;

	always #4 clk = ~clk;

	collatz_accelerated_step_counter_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.n_low     (n_low),
		.n_high    (n_high),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.steps     (steps),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Gap length for either side: mostly none, often short, now and then long.
	function automatic int unsigned idle_len();
		int unsigned r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Random start value: often short runs, some full width, a few near the
	// overflow boundary and a few trivial, power-of-two or all-ones patterns.
	function automatic value_t random_start();
		value_t      v;
		int unsigned pick;
		int unsigned len;
		v    = {$urandom, $urandom, $urandom, $urandom};
		pick = $urandom_range(0, 19);
		if (pick < 7) begin
			len = $urandom_range(1, 40);
			v &= (value_t'(1) << len) - 1;
		end else if (pick < 12) begin
			len = $urandom_range(41, 127);
			v &= (value_t'(1) << len) - 1;
		end else if (pick < 17) begin
			// keep full width
		end else if (pick < 19) begin
			v = {64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555}
				+ value_t'($urandom_range(0, 40)) - value_t'(20);
		end else begin
			case ($urandom_range(0, 3))
				0: v = '0;
				1: v = value_t'(1);
				2: v = value_t'(1) << $urandom_range(0, VALUE_WIDTH - 1);
				default: v = ~value_t'(0) >> $urandom_range(0, VALUE_WIDTH - 1);
			endcase
		end
		return v;
	endfunction

	// Offer one word and hold it until accepted; note it on acceptance.
	task automatic send_word(input logic [HALF_WIDTH-1:0] lo, input logic [HALF_WIDTH-1:0] hi);
		int unsigned gap;
		gap = idle_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		n_low    <= lo;
		n_high   <= hi;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_start(lo, hi);
	endtask

	// Drop valid and wait until every expected result is back.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the fuse only with the core idle.
	task automatic write_fuse(input logic [FUSE_W-1:0] value);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		sb.set_fuse(value);
		cfg_we    <= 1'b0;
	endtask

	task automatic send_random(input int unsigned count);
		value_t v;
		repeat (count) begin
			// pause the sender now and then until the core is empty
			if ($urandom_range(0, 49) == 0)
				drain();
			v = random_start();
			send_word(v[HALF_WIDTH-1:0], v[VALUE_WIDTH-1:HALF_WIDTH]);
		end
	endtask

	// ------------------------------------------------------------------------
	// Check every result word taken at a rising edge.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_outcome(status, steps);
	end

	// ------------------------------------------------------------------------
	// Receiver: random stalls, plus one long hold-off on request.
	// ------------------------------------------------------------------------
	initial begin
		int unsigned n;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
			end else begin
				n = idle_len();
				if (n == 0) begin
					out_ready <= 1'b1;
					@(posedge clk);
				end else begin
					out_ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sequence of phases.
	// ------------------------------------------------------------------------
	initial begin
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset fuse: zero input, one, small values, halves of 2^128, the
		// overflow boundary on both sides, all ones.
		send_word(64'd0, 64'd0);
		send_word(64'd1, 64'd0);
		send_word(64'd2, 64'd0);
		send_word(64'd3, 64'd0);
		send_word(64'd27, 64'd0);
		send_word(64'd63, 64'd0);
		send_word(64'h8000_0000_0000_0000, 64'd0);
		send_word(64'hFFFF_FFFF_FFFF_FFFF, 64'd0);
		send_word(64'd0, 64'd1);
		send_word(64'd1, 64'd1);
		send_word(64'd0, 64'h8000_0000_0000_0000);
		send_word(64'd1, 64'h8000_0000_0000_0000);
		send_word(64'd0, 64'hFFFF_FFFF_FFFF_FFFF);
		send_word(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		send_word(64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555);
		send_word(64'h5555_5555_5555_5553, 64'h5555_5555_5555_5555);
		send_word(64'h5555_5555_5555_5554, 64'h5555_5555_5555_5555);
		send_word(64'hAAAA_AAAA_AAAA_AAAA, 64'hAAAA_AAAA_AAAA_AAAA);

		// Zero fuse: any real pass trips it, overshoot shows on 2^127, an
		// overflow still wins over the fuse.
		write_fuse('0);
		send_word(64'd0, 64'd0);
		send_word(64'd1, 64'd0);
		send_word(64'd2, 64'd0);
		send_word(64'd0, 64'h8000_0000_0000_0000);
		send_word(64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555);

		// 27 takes exactly 111 steps: equal to the fuse passes, one less trips
		write_fuse(FUSE_W'(111));
		send_word(64'd27, 64'd0);
		write_fuse(FUSE_W'(110));
		send_word(64'd27, 64'd0);

		// Widest fuse, opening with a stretch of no idling at all.
		write_fuse({FUSE_W{1'b1}});
		steady = 1'b1;
		send_random(80);
		steady = 1'b0;
		send_random(180);

		// Small random fuse: many runs end on the limit.
		write_fuse(FUSE_W'($urandom_range(20, 400)));
		send_random(260);

		// Back to the reset value; long receiver hold-off while the sender
		// keeps offering short words, so the core backs up and stalls input.
		write_fuse(cstc_pkg::FUSE_RESET);
		hold_off_req = 1'b1;
		repeat (20)
			send_word(64'($urandom_range(1, 1 << 20)), 64'd0);
		send_random(240);

		// Random moderate fuse.
		write_fuse(FUSE_W'($urandom_range(0, 2000)));
		send_random(260);

		drain();
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Run limit, far above the slowest correct run.
	initial begin
		#200_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
